@@ hdl/tcpq_pkg.sv @@
// shared types and codes for the two-class priority queue
package tcpq_pkg;

   // field widths fixed by the item format
   localparam int DATA_W = 32;
   localparam int OCC_W  = 5;
   localparam int MODE_W = 2;
   localparam int STAT_W = 2;

   // operation carried by an input item
   typedef enum logic [MODE_W-1:0] {
      MODE_PLAIN = 2'd0,
      MODE_PRIO  = 2'd1,
      MODE_POP   = 2'd2,
      MODE_NOP   = 2'd3
   } tcpq_mode_type;

   // result status codes
   typedef enum logic [STAT_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } tcpq_stat_type;

   // cell row update applied when an item finishes
   typedef enum logic [1:0] {
      OP_NONE    = 2'd0,
      OP_TAIL    = 2'd1,
      OP_AT_SCAN = 2'd2,
      OP_POP     = 2'd3
   } tcpq_op_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DECODE = 2'd1,
      ST_SCAN   = 2'd2
   } tcpq_state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic          load;
      logic          scan_step;
      logic          finish;
      tcpq_op_type   op;
      tcpq_stat_type rsp_status;
   } tcpq_cmd_type;

   // status from datapath to controller
   typedef struct packed {
      tcpq_mode_type mode;
      logic          full;
      logic          empty;
      logic          item_urgent;
      logic          scan_stop;
      logic          out_busy;
   } tcpq_status_type;

endpackage

@@ hdl/tcpq_datapath.sv @@
// cell row, threshold register, run scan and result register
module tcpq_datapath
   import tcpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [DATA_W-1:0]   csr_wr_data,
   input  logic [MODE_W-1:0]   req_mode,
   input  logic [DATA_W-1:0]   req_value,
   input  logic                rsp_tready,
   output logic                rsp_valid,
   output logic                rsp_flag,
   output logic [DATA_W-1:0]   rsp_value,
   output logic [STAT_W-1:0]   rsp_status,
   output logic [OCC_W-1:0]    rsp_occ,
   input  tcpq_cmd_type        cmd,
   output tcpq_status_type     stat
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_W = $clog2(QUEUE_DEPTH);

   logic [DATA_W-1:0]      cell_ff [QUEUE_DEPTH];
   logic [DATA_W-1:0]      cell_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] flag_ff;
   logic [CNT_W-1:0]       count_ff;
   logic [CNT_W-1:0]       count_in;
   logic [IDX_W-1:0]       scan_ff;
   logic [DATA_W-1:0]      thresh_ff;
   tcpq_mode_type          mode_ff;
   logic [DATA_W-1:0]      value_ff;
   logic [CNT_W-1:0]       pos;
   logic [CNT_W+OCC_W-1:0] occ_wide;

   logic                   rsp_valid_ff;
   logic                   rsp_flag_ff;
   logic [DATA_W-1:0]      rsp_value_ff;
   logic [STAT_W-1:0]      rsp_status_ff;
   logic [OCC_W-1:0]       rsp_occ_ff;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= DATA_W'(60);
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   // latched item, per-cell urgency flags and scan index
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff  <= tcpq_mode_type'(req_mode);
         value_ff <= req_value;
         scan_ff  <= '0;
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            flag_ff[i] <= $signed(cell_ff[i]) >= $signed(thresh_ff);
         end
      end else if (cmd.scan_step) begin
         scan_ff <= scan_ff + IDX_W'(1);
      end
   end

   // insert position
   assign pos = (cmd.op == OP_AT_SCAN) ? CNT_W'(scan_ff) : count_ff;

   // per-cell next value: shift up behind the insert slot, or shift down on pop
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      always_comb begin
         cell_in[g] = cell_ff[g];
         if (cmd.finish) begin
            unique case (cmd.op)
               OP_TAIL, OP_AT_SCAN: begin
                  if (CNT_W'(g) == pos) begin
                     cell_in[g] = value_ff;
                  end else if ((g > 0) && (CNT_W'(g) > pos) && (CNT_W'(g) <= count_ff)) begin
                     cell_in[g] = cell_ff[(g > 0) ? g - 1 : 0];
                  end
               end
               OP_POP: begin
                  if (g < QUEUE_DEPTH - 1) begin
                     cell_in[g] = cell_ff[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                  end
               end
               default: begin
                  cell_in[g] = cell_ff[g];
               end
            endcase
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[g] <= cell_in[g];
      end
   end

   // entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.finish) begin
         unique case (cmd.op)
            OP_TAIL, OP_AT_SCAN: count_in = count_ff + CNT_W'(1);
            OP_POP:              count_in = count_ff - CNT_W'(1);
            default:             count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // occupancy reported modulo 32
   assign occ_wide = {{OCC_W{1'b0}}, count_in};

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_flag_ff   <= (cmd.op == OP_POP);
         rsp_value_ff  <= (cmd.op == OP_POP) ? cell_ff[0] : '0;
         rsp_status_ff <= cmd.rsp_status;
         rsp_occ_ff    <= occ_wide[OCC_W-1:0];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_flag   = rsp_flag_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_occ    = rsp_occ_ff;

   // status to controller
   always_comb begin
      stat.mode        = mode_ff;
      stat.full        = (count_ff == CNT_W'(QUEUE_DEPTH));
      stat.empty       = (count_ff == '0);
      stat.item_urgent = $signed(value_ff) >= $signed(thresh_ff);
      stat.scan_stop   = (CNT_W'(scan_ff) == count_ff) || !flag_ff[scan_ff];
      stat.out_busy    = rsp_valid_ff && !rsp_tready;
   end

endmodule

@@ hdl/tcpq_ctrl.sv @@
// controller state machine: decode, urgent-run scan and finish
module tcpq_ctrl
   import tcpq_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   output tcpq_cmd_type    cmd,
   input  tcpq_status_type stat
);

   tcpq_state_type state_ff;
   tcpq_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd.load       = 1'b0;
      cmd.scan_step  = 1'b0;
      cmd.finish     = 1'b0;
      cmd.op         = OP_NONE;
      cmd.rsp_status = STAT_OK;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if ((stat.mode == MODE_PRIO) && !stat.full && stat.item_urgent) begin
               state_in = ST_SCAN;
            end else if (!stat.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
               unique case (stat.mode)
                  MODE_PLAIN, MODE_PRIO: begin
                     if (stat.full) begin
                        cmd.rsp_status = STAT_FULL;
                     end else begin
                        cmd.op = OP_TAIL;
                     end
                  end
                  MODE_POP: begin
                     if (stat.empty) begin
                        cmd.rsp_status = STAT_EMPTY;
                     end else begin
                        cmd.op = OP_POP;
                     end
                  end
                  default: begin
                     cmd.op = OP_NONE;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (!stat.scan_stop) begin
               cmd.scan_step = 1'b1;
            end else if (!stat.out_busy) begin
               cmd.finish = 1'b1;
               cmd.op     = OP_AT_SCAN;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/two_class_priority_queue_top.sv @@
// top level of the two-class priority queue
// A bounded ordered queue of signed 32-bit values held in a row of shifting
// cells. Each item is a plain enqueue at the tail, a priority-aware enqueue
// (a value at or above urgent_threshold goes right after the leading run of
// urgent entries, other values go to the tail), or a dequeue of the head; each
// item yields exactly one result with status and occupancy. One item is in
// work at a time. An item passes through acceptance and a decode state to its
// result; an urgent priority-aware enqueue goes on from decode to a scan state,
// where the controller walks the leading urgent run one cell per cycle,
// comparing the latched per-cell urgency flags. A new item is taken in the cycle
// after a result is written. A result waits in an output register; while it is
// not taken, the next item is accepted and then holds before finishing.
module two_class_priority_queue_top
   import tcpq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data,   // urgent_threshold
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,     // [31:0] item_value
   input  logic [1:0]  req_tuser,     // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,     // [31:0] out_value, [36:32] occupancy, zero fill
   output logic [2:0]  rsp_tuser      // [0] out_valid, [2:1] status
);

   tcpq_cmd_type      cmd;
   tcpq_status_type   stat;
   logic              rsp_flag;
   logic [DATA_W-1:0] rsp_value;
   logic [STAT_W-1:0] rsp_status;
   logic [OCC_W-1:0]  rsp_occ;

   // controller
   tcpq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .stat       (stat)
   );

   // datapath
   tcpq_datapath #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_mode    (req_tuser),
      .req_value   (req_tdata),
      .rsp_tready  (rsp_tready),
      .rsp_valid   (rsp_tvalid),
      .rsp_flag    (rsp_flag),
      .rsp_value   (rsp_value),
      .rsp_status  (rsp_status),
      .rsp_occ     (rsp_occ),
      .cmd         (cmd),
      .stat        (stat)
   );

   // result packing
   assign rsp_tdata = {3'b000, rsp_occ, rsp_value};
   assign rsp_tuser = {rsp_status, rsp_flag};

endmodule
